@@ hw/rtl/xbmf_pkg.sv @@
// Package with shared constants and types of the x86 branch address MRU filter.
package xbmf_pkg;
    localparam int ListDepth = 16;
    localparam int IdxW = $clog2(ListDepth);
    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_DIRECTION = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_ESCAPE = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_START = 2'd2;
    localparam logic [7:0] OP_CALL = 8'hE8;
    localparam logic [7:0] OP_JUMP = 8'hE9;
    localparam logic [7:0] OP_TWO_BYTE = 8'h0F;
    localparam logic [7:0] JCC_MASK = 8'hF0;
    localparam logic [7:0] JCC_HIGH = 8'h80;
    localparam logic [7:0] BYTE_ONES = 8'hFF;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    typedef struct packed {
        logic       direction;
        logic [7:0] escape_byte;
    } cfg_t;
endpackage

@@ hw/rtl/xbmf_if.sv @@
// Valid-ready channel interfaces for input items, results and configuration.
interface xbmf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;
    modport source (output valid, data_byte, restart, input ready);
    modport sink (input valid, data_byte, restart, output ready);
endinterface

interface xbmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    modport source (output valid, out_byte, last_of_run, input ready);
    modport sink (input valid, out_byte, last_of_run, output ready);
endinterface

interface xbmf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/xbmf_list.sv @@
// Move-to-front list held in a synchronous memory with a read-modify-write sequencer.
module xbmf_list (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     clear,
    input  logic                     start,
    input  logic                     by_index,
    input  logic [xbmf_pkg::IdxW-1:0] index,
    input  logic [31:0]              value,
    output logic                     done,
    output logic [xbmf_pkg::IdxW-1:0] hit_index,
    output logic [31:0]              found
);
    import xbmf_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_DONE}
        state_t;

    logic [31:0]     mem [ListDepth];
    logic [ListDepth-1:0] valid_reg;
    state_t          state_reg;
    logic [IdxW-1:0] addr_reg;
    logic [IdxW-1:0] pos_reg;
    logic [31:0]     key_reg;
    logic [31:0]     rdata_reg;
    logic            rvalid_reg;
    logic            by_index_reg;
    logic            done_reg;
    logic [IdxW-1:0] hit_reg;
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [31:0]     wdata;
    logic [31:0]     rd_now;

    assign rd_now = rvalid_reg ? rdata_reg : 32'd0;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[addr_reg];
    end

    always_comb
    begin
        we = 1'b0;
        waddr = pos_reg;
        wdata = rd_now;
        if (state_reg == S_SHIFT_WR)
        begin
            we = 1'b1;
            if (pos_reg == '0)
            begin
                wdata = key_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            addr_reg <= '0;
            pos_reg <= '0;
            key_reg <= '0;
            rvalid_reg <= 1'b0;
            by_index_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            rvalid_reg <= valid_reg[addr_reg];
            if (clear)
            begin
                valid_reg <= '0;
                state_reg <= S_IDLE;
            end
            else
            begin
                unique case (state_reg)
                    S_IDLE:
                    begin
                        if (start)
                        begin
                            by_index_reg <= by_index;
                            key_reg <= value;
                            addr_reg <= by_index ? index : '0;
                            pos_reg <= by_index ? index : '0;
                            state_reg <= S_READ;
                        end
                    end
                    S_READ:
                    begin
                        state_reg <= S_SCAN;
                    end
                    S_SCAN:
                    begin
                        if (by_index_reg)
                        begin
                            key_reg <= rd_now;
                            by_index_reg <= 1'b0;
                            pos_reg <= '0;
                            addr_reg <= '0;
                            state_reg <= S_READ;
                        end
                        else if (rd_now == key_reg || pos_reg == IdxW'(ListDepth - 1))
                        begin
                            addr_reg <= pos_reg - 1'b1;
                            state_reg <= S_SHIFT_RD;
                        end
                        else
                        begin
                            pos_reg <= pos_reg + 1'b1;
                            addr_reg <= pos_reg + 1'b1;
                            state_reg <= S_READ;
                        end
                    end
                    S_SHIFT_RD:
                    begin
                        state_reg <= S_SHIFT_WR;
                    end
                    S_SHIFT_WR:
                    begin
                        valid_reg[pos_reg] <= 1'b1;
                        if (pos_reg == '0)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            pos_reg <= pos_reg - 1'b1;
                            addr_reg <= pos_reg - 2'd2;
                            state_reg <= S_SHIFT_RD;
                        end
                    end
                    S_DONE:
                    begin
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SCAN)
        begin
            hit_reg <= pos_reg;
        end
    end

    assign done = done_reg;
    assign hit_index = hit_reg;
    assign found = key_reg;
endmodule

@@ hw/rtl/x86_branch_address_mru_filter_top.sv @@
// Top level of the x86 branch address filter with move-to-front lists.
// A passed byte is offered the cycle after it is taken, one per cycle while the output is free.
// A finished capture that needs a list waits while the list sequencer reads the indexed entry for a
// decode, reads and compares each searched entry, reads and writes each moved entry and then finishes;
// after that its five beats leave one per cycle while the output is free; input waits meanwhile.
// Reset loads the register defaults and empties both lists through valid bits.
module x86_branch_address_mru_filter_top (
    input logic         clk,
    input logic         rst_n,
    xbmf_in_if.sink     in_ch,
    xbmf_out_if.source  out_ch,
    xbmf_cfg_if.sink    cfg_ch
);
    import xbmf_pkg::*;

    typedef enum logic [1:0] {T_RUN, T_LIST, T_SEND} state_t;

    cfg_t        cfg_reg;
    logic [30:0] start_reg;
    state_t      state_reg;
    logic [31:0] pos_reg;
    logic [7:0]  prev_reg;
    logic        capt_reg;
    logic [2:0]  cnt_reg;
    logic [7:0]  cb_reg [5];
    logic [7:0]  ob_reg [5];
    logic [2:0]  send_reg;
    logic        ov_reg;
    logic [7:0]  obyte_reg;
    logic        olast_reg;
    logic        is_call_reg;
    logic [31:0] cap_pos_reg;

    logic        acc;
    logic        start_cap;
    logic        cap_now;
    logic [2:0]  cnt_now;
    logic        clear;
    logic        list_start;
    logic        list_by_index;
    logic [IdxW-1:0] list_index;
    logic [31:0] list_value;
    logic        call_done, jump_done;
    logic [IdxW-1:0] call_hit, jump_hit;
    logic [31:0] call_found, jump_found;
    logic        ldone;
    logic [IdxW-1:0] lhit;
    logic [31:0] lfound;
    logic [7:0]  nb [5];
    logic        need_list;
    logic        by_idx;
    logic [31:0] val;
    logic [31:0] enc_v;
    logic [31:0] sx;
    logic        out_free;

    assign cfg_ch.ready = 1'b1;
    assign out_free = !ov_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == T_RUN) && out_free;
    assign acc = in_ch.valid && in_ch.ready;
    assign clear = acc && in_ch.restart;
    assign start_cap = in_ch.data_byte == OP_CALL || in_ch.data_byte == OP_JUMP
        || ((in_ch.data_byte & JCC_MASK) == JCC_HIGH
        && (in_ch.restart ? BYTE_ZERO : prev_reg) == OP_TWO_BYTE);
    assign cap_now = (in_ch.restart ? 1'b0 : capt_reg) || start_cap;
    assign cnt_now = in_ch.restart ? 3'd0 : cnt_reg;

    always_comb
    begin
        for (int k = 0; k < 5; k++)
        begin
            nb[k] = cb_reg[k];
        end
        if (acc)
        begin
            nb[4] = in_ch.data_byte;
        end
        need_list = 1'b0;
        by_idx = 1'b0;
        sx = '0;
        val = {nb[4], nb[3], nb[2], nb[1]};
        if (!cfg_reg.direction)
        begin
            need_list = nb[4] == BYTE_ZERO || nb[4] == BYTE_ONES;
        end
        else if (nb[4] == cfg_reg.escape_byte)
        begin
            need_list = nb[1] == BYTE_ONES && nb[2] == BYTE_ONES
                && {24'd0, nb[3]} < 32'(ListDepth);
            by_idx = 1'b1;
        end
        else if (nb[4] == BYTE_ZERO || nb[4] == BYTE_ONES)
        begin
            sx = {nb[4], nb[1], nb[2], nb[3]} - pos_reg;
            val = {{7{sx[24]}}, sx[24:0]};
            need_list = 1'b1;
        end
    end

    assign list_index = IdxW'(nb[3]);
    assign list_value = val;
    assign list_by_index = by_idx;
    assign list_start = acc && !clear && capt_reg && cnt_reg == 3'd4 && need_list;

    xbmf_list u_call (
        .clk(clk), .rst_n(rst_n), .clear(clear),
        .start(list_start && nb[0] == OP_CALL),
        .by_index(list_by_index), .index(list_index), .value(list_value),
        .done(call_done), .hit_index(call_hit), .found(call_found)
    );

    xbmf_list u_jump (
        .clk(clk), .rst_n(rst_n), .clear(clear),
        .start(list_start && nb[0] != OP_CALL),
        .by_index(list_by_index), .index(list_index), .value(list_value),
        .done(jump_done), .hit_index(jump_hit), .found(jump_found)
    );

    assign ldone = is_call_reg ? call_done : jump_done;
    assign lhit = is_call_reg ? call_hit : jump_hit;
    assign lfound = is_call_reg ? call_found : jump_found;
    assign enc_v = {cb_reg[4], cb_reg[3], cb_reg[2], cb_reg[1]} + cap_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{direction: 1'b0, escape_byte: 8'd128};
            start_reg <= 31'd65;
            state_reg <= T_RUN;
            pos_reg <= 32'd65;
            prev_reg <= '0;
            capt_reg <= 1'b0;
            cnt_reg <= '0;
            send_reg <= '0;
            ov_reg <= 1'b0;
            obyte_reg <= '0;
            olast_reg <= 1'b0;
            is_call_reg <= 1'b0;
            cap_pos_reg <= '0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                unique case (cfg_ch.index)
                    CFG_DIRECTION: cfg_reg.direction <= cfg_ch.data[0];
                    CFG_ESCAPE: cfg_reg.escape_byte <= cfg_ch.data[7:0];
                    CFG_START: start_reg <= cfg_ch.data[30:0];
                    default: ;
                endcase
            end
            if ((state_reg == T_RUN && acc && !cap_now) || (state_reg == T_SEND && out_free))
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                T_RUN:
                begin
                    if (acc)
                    begin
                        pos_reg <= (in_ch.restart ? {1'b0, start_reg} : pos_reg) + 32'd1;
                        prev_reg <= in_ch.data_byte;
                        if (cap_now)
                        begin
                            cb_reg[cnt_now] <= in_ch.data_byte;
                            if (cnt_now == 3'd4)
                            begin
                                capt_reg <= 1'b0;
                                cnt_reg <= '0;
                                is_call_reg <= nb[0] == OP_CALL;
                                cap_pos_reg <= pos_reg;
                                for (int k = 0; k < 5; k++)
                                begin
                                    ob_reg[k] <= nb[k];
                                end
                                state_reg <= need_list ? T_LIST : T_SEND;
                                send_reg <= '0;
                            end
                            else
                            begin
                                capt_reg <= 1'b1;
                                cnt_reg <= cnt_now + 3'd1;
                            end
                        end
                        else
                        begin
                            capt_reg <= 1'b0;
                            cnt_reg <= '0;
                            obyte_reg <= in_ch.data_byte;
                            olast_reg <= 1'b1;
                        end
                    end
                end
                T_LIST:
                begin
                    if (ldone)
                    begin
                        if (cfg_reg.direction)
                        begin
                            ob_reg[1] <= lfound[7:0];
                            ob_reg[2] <= lfound[15:8];
                            ob_reg[3] <= lfound[23:16];
                            ob_reg[4] <= lfound[31:24];
                        end
                        else if (lhit != IdxW'(ListDepth - 1))
                        begin
                            ob_reg[1] <= BYTE_ONES;
                            ob_reg[2] <= BYTE_ONES;
                            ob_reg[3] <= 8'(lhit);
                            ob_reg[4] <= cfg_reg.escape_byte;
                        end
                        else
                        begin
                            ob_reg[1] <= enc_v[23:16];
                            ob_reg[2] <= enc_v[15:8];
                            ob_reg[3] <= enc_v[7:0];
                            ob_reg[4] <= {8{enc_v[24]}};
                        end
                        state_reg <= T_SEND;
                    end
                end
                T_SEND:
                begin
                    if (out_free)
                    begin
                        obyte_reg <= ob_reg[send_reg];
                        olast_reg <= send_reg == 3'd4;
                        send_reg <= send_reg + 3'd1;
                        if (send_reg == 3'd4)
                        begin
                            state_reg <= T_RUN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= T_RUN;
                end
            endcase
        end
    end

    assign out_ch.valid = ov_reg;
    assign out_ch.out_byte = obyte_reg;
    assign out_ch.last_of_run = olast_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != T_RUN |-> !in_ch.ready)
        else $error("input taken while a capture is busy");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("capture count out of range");
    a_send_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == T_SEND && out_free && send_reg == 3'd4 |=> olast_reg && ov_reg)
        else $error("final beat of a capture not marked last");
endmodule
